// File: rtl/frame_difference_motion_detector_top_assert.svh
// Assertion macros shared by the frame difference motion detector RTL.
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_TOP_ASSERT_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FDMD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fdmd assertion failed");
`define FDMD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("fdmd forbidden condition");
`else
`define FDMD_ASSERT(lbl, clk, rst_n, prop)
`define FDMD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/fdmd_pkg.sv
// Types, constants and helper functions of the frame difference motion detector.
`timescale 1ns / 1ps
`default_nettype none
package fdmd_pkg;

  localparam int PIX_W    = 8;
  localparam int POS_W    = 11;
  localparam int SIZE_W   = 12;
  localparam int COUNT_W  = 23;
  localparam int SUM_W    = 33;
  localparam int REGION_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int DIV_STEPS = SUM_W;
  localparam int STEP_W = $clog2(DIV_STEPS + 1);

  localparam logic [PIX_W-1:0]   PIX_WHITE   = 8'd255;
  localparam logic [PIX_W-1:0]   THRESH_DEF  = 8'd30;
  localparam logic [COUNT_W-1:0] MIN_DEF     = 23'd100;
  localparam logic [SIZE_W-1:0]  WIDTH_DEF   = 12'd640;
  localparam logic [SIZE_W-1:0]  HEIGHT_DEF  = 12'd480;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
  localparam logic [SUM_W-1:0]   SUM_MAX     = '1;
  localparam logic [POS_W-1:0]   CENT_MAX    = '1;

  localparam logic [16:0] RECIP3 = 17'd43691;

  typedef enum logic [1:0] {
    REG_DIFF_THRESHOLD,
    REG_MIN_CHANGED,
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } reg_idx_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  typedef struct packed {
    logic [PIX_W-1:0]   thr;
    logic [COUNT_W-1:0] min_changed;
    logic [SIZE_W-1:0]  w_last;
    logic [SIZE_W-1:0]  h_last;
    logic [SIZE_W-1:0]  w_third;
    logic [SIZE_W-1:0]  w_two3;
    logic [SIZE_W-1:0]  h_third;
    logic [SIZE_W-1:0]  h_two3;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   disp;
    logic               frame_end;
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum_x;
    logic [SUM_W-1:0]   sum_y;
  } entry_t;

  // floor(x / 3) for x below 12288, by reciprocal multiply
  function automatic logic [SIZE_W-1:0] div3(input logic [SIZE_W+1:0] x);
    logic [30:0] prod;
    prod = 31'(x) * 31'(RECIP3);
    return prod[28:17];
  endfunction

endpackage
`default_nettype wire

// File: rtl/frame_difference_motion_detector_top.sv
// Top level of the frame difference motion detector.
// Pixel pairs arrive in raster order and each yields one overlay pixel. The front end
// classifies one pixel per clock while the queue has room and feeds a four-entry queue;
// the back end drains it at one pixel per clock while the output is free and no division
// runs. Each result passes through a queue slot and the output register. The last pixel
// of a frame that shows motion runs a 33-step restoring divider for the centroid and holds
// the back end; the queue absorbs four pixels, then in_ready drops until the divide ends.
`timescale 1ns / 1ps
`default_nettype none
module frame_difference_motion_detector_top #(
  parameter int MAX_WIDTH  = fdmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fdmd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [fdmd_pkg::PIX_W-1:0]        in_old_pixel,
  input  wire logic [fdmd_pkg::PIX_W-1:0]        in_new_pixel,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [fdmd_pkg::PIX_W-1:0]             out_display_pixel,
  output logic                                   out_frame_end,
  output logic                                   out_motion_found,
  output logic [fdmd_pkg::REGION_W-1:0]          out_region,
  output logic [fdmd_pkg::POS_W-1:0]             out_centroid_x,
  output logic [fdmd_pkg::POS_W-1:0]             out_centroid_y,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [fdmd_pkg::CFG_ADDR_W-1:0]   paddr,
  input  wire logic [fdmd_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic      [fdmd_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                                   pready
);

  fdmd_pkg::cfg_t   cfg;
  fdmd_pkg::entry_t front_entry;
  fdmd_pkg::entry_t head;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;

  assign in_ready = !full;
  assign push     = in_valid && !full;

  fdmd_cfg #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg)
  );

  fdmd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .push     (push),
    .old_pixel(in_old_pixel),
    .new_pixel(in_new_pixel),
    .entry    (front_entry)
  );

  fdmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(front_entry),
    .full      (full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  fdmd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .head             (head),
    .empty            (empty),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_display_pixel(out_display_pixel),
    .out_frame_end    (out_frame_end),
    .out_motion_found (out_motion_found),
    .out_region       (out_region),
    .out_centroid_x   (out_centroid_x),
    .out_centroid_y   (out_centroid_y)
  );

endmodule
`default_nettype wire

// File: rtl/fdmd_cfg.sv
// APB register file and derived frame geometry of the motion detector.
`timescale 1ns / 1ps
`default_nettype none
module fdmd_cfg #(
  parameter int MAX_WIDTH  = fdmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = fdmd_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [fdmd_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [fdmd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic      [fdmd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                                 pready,
  output fdmd_pkg::cfg_t                       cfg
);

  localparam int EW = fdmd_pkg::SIZE_W + 1;
  localparam logic [EW-1:0] MAX_W = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MAX_H = EW'(MAX_HEIGHT);

  logic [fdmd_pkg::PIX_W-1:0]   thr_r;
  logic [fdmd_pkg::COUNT_W-1:0] min_r;
  logic [fdmd_pkg::SIZE_W-1:0]  width_r;
  logic [fdmd_pkg::SIZE_W-1:0]  height_r;
  logic                         wr;
  fdmd_pkg::reg_idx_t           idx;
  logic [EW-1:0]                w_eff;
  logic [EW-1:0]                h_eff;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = fdmd_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= fdmd_pkg::THRESH_DEF;
      min_r    <= fdmd_pkg::MIN_DEF;
      width_r  <= fdmd_pkg::WIDTH_DEF;
      height_r <= fdmd_pkg::HEIGHT_DEF;
    end else if (wr) begin
      case (idx)
        fdmd_pkg::REG_DIFF_THRESHOLD: thr_r    <= pwdata[fdmd_pkg::PIX_W-1:0];
        fdmd_pkg::REG_MIN_CHANGED:    min_r    <= pwdata[fdmd_pkg::COUNT_W-1:0];
        fdmd_pkg::REG_FRAME_WIDTH:    width_r  <= pwdata[fdmd_pkg::SIZE_W-1:0];
        fdmd_pkg::REG_FRAME_HEIGHT:   height_r <= pwdata[fdmd_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fdmd_pkg::REG_DIFF_THRESHOLD: prdata = fdmd_pkg::CFG_DATA_W'(thr_r);
      fdmd_pkg::REG_MIN_CHANGED:    prdata = fdmd_pkg::CFG_DATA_W'(min_r);
      fdmd_pkg::REG_FRAME_WIDTH:    prdata = fdmd_pkg::CFG_DATA_W'(width_r);
      fdmd_pkg::REG_FRAME_HEIGHT:   prdata = fdmd_pkg::CFG_DATA_W'(height_r);
      default:                      prdata = '0;
    endcase
  end

  always_comb begin
    if (width_r == '0) w_eff = EW'(1);
    else if ({1'b0, width_r} > MAX_W) w_eff = MAX_W;
    else w_eff = {1'b0, width_r};
    if (height_r == '0) h_eff = EW'(1);
    else if ({1'b0, height_r} > MAX_H) h_eff = MAX_H;
    else h_eff = {1'b0, height_r};
  end

  always_comb begin
    cfg.thr         = thr_r;
    cfg.min_changed = min_r;
    cfg.w_last      = fdmd_pkg::SIZE_W'(w_eff - EW'(1));
    cfg.h_last      = fdmd_pkg::SIZE_W'(h_eff - EW'(1));
    cfg.w_third     = fdmd_pkg::div3({1'b0, w_eff});
    cfg.w_two3      = fdmd_pkg::div3({w_eff, 1'b0});
    cfg.h_third     = fdmd_pkg::div3({1'b0, h_eff});
    cfg.h_two3      = fdmd_pkg::div3({h_eff, 1'b0});
  end

endmodule
`default_nettype wire

// File: rtl/fdmd_front.sv
// Front end: position tracking, change classification and per-frame accumulation.
`timescale 1ns / 1ps
`default_nettype none
module fdmd_front (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire fdmd_pkg::cfg_t             cfg,
  input  wire logic                       push,
  input  wire logic [fdmd_pkg::PIX_W-1:0] old_pixel,
  input  wire logic [fdmd_pkg::PIX_W-1:0] new_pixel,
  output fdmd_pkg::entry_t                entry
);

  localparam int PW = fdmd_pkg::POS_W;
  localparam int SW = fdmd_pkg::SUM_W;

  logic [PW-1:0]                col_r, col_nxt;
  logic [PW-1:0]                row_r, row_nxt;
  logic [fdmd_pkg::COUNT_W-1:0] count_r, count_nxt, count_acc;
  logic [SW-1:0]                sumx_r, sumx_nxt, sumx_acc;
  logic [SW-1:0]                sumy_r, sumy_nxt, sumy_acc;
  logic [fdmd_pkg::PIX_W-1:0]   diff;
  logic                         changed;
  logic                         grid;
  logic                         last_col;
  logic                         last_row;
  logic [SW:0]                  sumx_add;
  logic [SW:0]                  sumy_add;

  always_comb begin
    diff     = (old_pixel > new_pixel) ? old_pixel - new_pixel : new_pixel - old_pixel;
    changed  = diff > cfg.thr;
    grid     = ({1'b0, row_r} == cfg.h_third) || ({1'b0, row_r} == cfg.h_two3) ||
               ({1'b0, col_r} == cfg.w_third) || ({1'b0, col_r} == cfg.w_two3);
    last_col = {1'b0, col_r} >= cfg.w_last;
    last_row = {1'b0, row_r} >= cfg.h_last;

    sumx_add = {1'b0, sumx_r} + (SW+1)'(col_r);
    sumy_add = {1'b0, sumy_r} + (SW+1)'(row_r);
    if (changed) begin
      count_acc = (count_r == fdmd_pkg::COUNT_MAX) ? count_r : count_r + 1'b1;
      sumx_acc  = sumx_add[SW] ? fdmd_pkg::SUM_MAX : sumx_add[SW-1:0];
      sumy_acc  = sumy_add[SW] ? fdmd_pkg::SUM_MAX : sumy_add[SW-1:0];
    end else begin
      count_acc = count_r;
      sumx_acc  = sumx_r;
      sumy_acc  = sumy_r;
    end

    entry.disp      = (changed || grid) ? fdmd_pkg::PIX_WHITE : new_pixel;
    entry.frame_end = last_col && last_row;
    entry.count     = count_acc;
    entry.sum_x     = sumx_acc;
    entry.sum_y     = sumy_acc;

    if (entry.frame_end) begin
      count_nxt = '0;
      sumx_nxt  = '0;
      sumy_nxt  = '0;
    end else begin
      count_nxt = count_acc;
      sumx_nxt  = sumx_acc;
      sumy_nxt  = sumy_acc;
    end

    if (last_col) begin
      col_nxt = '0;
      row_nxt = last_row ? '0 : row_r + 1'b1;
    end else begin
      col_nxt = col_r + 1'b1;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      count_r <= '0;
      sumx_r  <= '0;
      sumy_r  <= '0;
    end else if (push) begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      count_r <= count_nxt;
      sumx_r  <= sumx_nxt;
      sumy_r  <= sumy_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/fdmd_queue.sv
// Short queue of classified pixels between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_difference_motion_detector_top_assert.svh"
module fdmd_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire fdmd_pkg::entry_t push_entry,
  output logic                  full,
  input  wire logic             pop,
  output fdmd_pkg::entry_t      head,
  output logic                  empty
);

  localparam int DEPTH = fdmd_pkg::QUEUE_DEPTH;
  localparam int AW    = fdmd_pkg::QPTR_W;
  localparam int CW    = fdmd_pkg::QCNT_W;

  fdmd_pkg::entry_t slots_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r;
  logic [AW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;
  assign head  = slots_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop) count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  `FDMD_ASSERT(a_q_count_bound, clk, rst_n, count_r <= CW'(DEPTH))
  `FDMD_ASSERT_NEVER(a_q_pop_empty, clk, rst_n, pop && empty)
  `FDMD_ASSERT_NEVER(a_q_push_full, clk, rst_n, push && full)

endmodule
`default_nettype wire

// File: rtl/fdmd_back.sv
// Back end: frame-end centroid division, region lookup and output register.
`timescale 1ns / 1ps
`default_nettype none
`include "frame_difference_motion_detector_top_assert.svh"
module fdmd_back (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire fdmd_pkg::cfg_t                cfg,
  input  wire fdmd_pkg::entry_t              head,
  input  wire logic                          empty,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [fdmd_pkg::PIX_W-1:0]         out_display_pixel,
  output logic                               out_frame_end,
  output logic                               out_motion_found,
  output logic [fdmd_pkg::REGION_W-1:0]      out_region,
  output logic [fdmd_pkg::POS_W-1:0]         out_centroid_x,
  output logic [fdmd_pkg::POS_W-1:0]         out_centroid_y
);

  localparam int SW = fdmd_pkg::SUM_W;
  localparam int DW = fdmd_pkg::COUNT_W;
  localparam int PW = fdmd_pkg::POS_W;

  fdmd_pkg::back_state_t state_r, state_nxt;
  logic [fdmd_pkg::STEP_W-1:0] step_r;
  logic [DW-1:0]               divisor_r;
  logic [SW-1:0]               dvd_x_r, dvd_y_r;
  logic [SW-1:0]               qx_r, qy_r;
  logic [DW-1:0]               rem_x_r, rem_y_r;
  logic [fdmd_pkg::PIX_W-1:0]  hold_disp_r;

  logic                        out_valid_r;
  logic [fdmd_pkg::PIX_W-1:0]  disp_r;
  logic                        fend_r;
  logic                        motion_r;
  logic [fdmd_pkg::REGION_W-1:0] region_r;
  logic [PW-1:0]               cx_r, cy_r;

  logic        out_free;
  logic        motion_hit;
  logic        start_div;
  logic        load_direct;
  logic        load_result;
  logic [DW:0] shx, shy;
  logic        gex, gey;
  logic [PW-1:0] cx, cy;
  logic [1:0]  cb, rb;
  logic [fdmd_pkg::REGION_W-1:0] region;

  assign out_free   = !out_valid_r || out_ready;
  assign motion_hit = head.count > cfg.min_changed;

  always_comb begin
    state_nxt   = state_r;
    pop         = 1'b0;
    start_div   = 1'b0;
    load_direct = 1'b0;
    load_result = 1'b0;
    case (state_r)
      fdmd_pkg::BK_IDLE: begin
        if (!empty && out_free) begin
          pop = 1'b1;
          if (head.frame_end && motion_hit) begin
            start_div = 1'b1;
            state_nxt = fdmd_pkg::BK_DIV;
          end else begin
            load_direct = 1'b1;
          end
        end
      end
      fdmd_pkg::BK_DIV: begin
        if (step_r == fdmd_pkg::STEP_W'(1)) state_nxt = fdmd_pkg::BK_FIN;
      end
      fdmd_pkg::BK_FIN: begin
        if (out_free) begin
          load_result = 1'b1;
          state_nxt   = fdmd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = fdmd_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= fdmd_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    shx = {rem_x_r, dvd_x_r[SW-1]};
    shy = {rem_y_r, dvd_y_r[SW-1]};
    gex = shx >= {1'b0, divisor_r};
    gey = shy >= {1'b0, divisor_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start_div) begin
      step_r <= fdmd_pkg::STEP_W'(fdmd_pkg::DIV_STEPS);
    end else if (state_r == fdmd_pkg::BK_DIV) begin
      step_r <= step_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_div) begin
      divisor_r   <= head.count;
      dvd_x_r     <= head.sum_x;
      dvd_y_r     <= head.sum_y;
      rem_x_r     <= '0;
      rem_y_r     <= '0;
      qx_r        <= '0;
      qy_r        <= '0;
      hold_disp_r <= head.disp;
    end else if (state_r == fdmd_pkg::BK_DIV) begin
      rem_x_r <= gex ? DW'(shx - {1'b0, divisor_r}) : shx[DW-1:0];
      rem_y_r <= gey ? DW'(shy - {1'b0, divisor_r}) : shy[DW-1:0];
      dvd_x_r <= {dvd_x_r[SW-2:0], 1'b0};
      dvd_y_r <= {dvd_y_r[SW-2:0], 1'b0};
      qx_r    <= {qx_r[SW-2:0], gex};
      qy_r    <= {qy_r[SW-2:0], gey};
    end
  end

  always_comb begin
    cx = (qx_r > SW'(fdmd_pkg::CENT_MAX)) ? fdmd_pkg::CENT_MAX : qx_r[PW-1:0];
    cy = (qy_r > SW'(fdmd_pkg::CENT_MAX)) ? fdmd_pkg::CENT_MAX : qy_r[PW-1:0];
    if ({1'b0, cx} < cfg.w_third) cb = 2'd0;
    else if ({1'b0, cx} < cfg.w_two3) cb = 2'd1;
    else cb = 2'd2;
    if ({1'b0, cy} < cfg.h_third) rb = 2'd0;
    else if ({1'b0, cy} < cfg.h_two3) rb = 2'd1;
    else rb = 2'd2;
    region = {2'b00, rb} + {1'b0, rb, 1'b0} + {2'b00, cb} + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (load_direct || load_result) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load_direct) begin
      disp_r   <= head.disp;
      fend_r   <= head.frame_end;
      motion_r <= 1'b0;
      region_r <= '0;
      cx_r     <= '0;
      cy_r     <= '0;
    end else if (load_result) begin
      disp_r   <= hold_disp_r;
      fend_r   <= 1'b1;
      motion_r <= 1'b1;
      region_r <= region;
      cx_r     <= cx;
      cy_r     <= cy;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_display_pixel = disp_r;
  assign out_frame_end     = fend_r;
  assign out_motion_found  = motion_r;
  assign out_region        = region_r;
  assign out_centroid_x    = cx_r;
  assign out_centroid_y    = cy_r;

  `FDMD_ASSERT(a_no_pop_busy, clk, rst_n, (state_r != fdmd_pkg::BK_IDLE) |-> !pop)
  `FDMD_ASSERT(a_fin_steps_done, clk, rst_n, (state_r == fdmd_pkg::BK_FIN) |-> (step_r == '0))
  `FDMD_ASSERT(a_motion_region, clk, rst_n, (out_valid_r && motion_r) |-> (fend_r && region_r != '0))

endmodule
`default_nettype wire

// File: verif/frame_difference_motion_detector_top_tb.sv
// Self-checking testbench: directed and random pixel-pair streams scored against an in-bench predictor.
`timescale 1ns / 1ps
module frame_difference_motion_detector_top_tb;
  import fdmd_pkg::*;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 8;
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 20;
  localparam int NUM_PHASES  = 13;

  typedef struct packed {
    logic [PIX_W-1:0]    display_pixel;
    logic                frame_end;
    logic                motion_found;
    logic [REGION_W-1:0] region;
    logic [POS_W-1:0]    centroid_x;
    logic [POS_W-1:0]    centroid_y;
  } overlay_t;

  typedef enum logic {
    ROW_PIXEL,
    ROW_WRITE
  } row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    reg_idx_t              idx;
    logic [CFG_DATA_W-1:0] value;
    logic [PIX_W-1:0]      old_pixel;
    logic [PIX_W-1:0]      new_pixel;
    logic                  typed;
    overlay_t              want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [PIX_W-1:0]      in_old_pixel = '0;
  logic [PIX_W-1:0]      in_new_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [PIX_W-1:0]      out_display_pixel;
  logic                  out_frame_end;
  logic                  out_motion_found;
  logic [REGION_W-1:0]   out_region;
  logic [POS_W-1:0]      out_centroid_x;
  logic [POS_W-1:0]      out_centroid_y;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [PIX_W-1:0]   thr_setting = THRESH_DEF;
  logic [COUNT_W-1:0] min_changed_setting = MIN_DEF;
  logic [SIZE_W-1:0]  width_setting = WIDTH_DEF;
  logic [SIZE_W-1:0]  height_setting = HEIGHT_DEF;
  logic [POS_W-1:0]   col_pos = '0;
  logic [POS_W-1:0]   row_pos = '0;
  logic [COUNT_W-1:0] changed_count = '0;
  logic [SUM_W-1:0]   sum_col = '0;
  logic [SUM_W-1:0]   sum_row = '0;

  overlay_t    expected_overlay_q[$];
  stim_row_t   directed_rows[$];
  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  int unsigned pixels_sent = 0;
  int unsigned frames_closed = 0;
  int unsigned motion_frames = 0;
  int unsigned reg_writes = 0;
  int          stall_left = 0;
  bit          gaps_enabled = 1'b1;
  bit          stalls_enabled = 1'b1;

  frame_difference_motion_detector_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_old_pixel      (in_old_pixel),
    .in_new_pixel      (in_new_pixel),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_display_pixel (out_display_pixel),
    .out_frame_end     (out_frame_end),
    .out_motion_found  (out_motion_found),
    .out_region        (out_region),
    .out_centroid_x    (out_centroid_x),
    .out_centroid_y    (out_centroid_y),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time, cycle_count,
               expected_overlay_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic int used_size(input logic [SIZE_W-1:0] v, input int max_size);
    if (v == '0) return 1;
    if (int'(v) > max_size) return max_size;
    return int'(v);
  endfunction

  function automatic int grid_band(input int pos, input int size);
    if (pos < size / 3) return 0;
    if (pos < (2 * size) / 3) return 1;
    return 2;
  endfunction

  function automatic overlay_t predict_overlay(input logic [PIX_W-1:0] oldp,
                                               input logic [PIX_W-1:0] newp);
    overlay_t         res;
    int               w;
    int               h;
    int               diff;
    int               col;
    int               row;
    bit               last_col;
    bit               last_row;
    logic [SUM_W:0]   acc;
    logic [63:0]      ax;
    logic [63:0]      ay;
    res = '0;
    w = used_size(width_setting, MAX_WIDTH_DEF);
    h = used_size(height_setting, MAX_HEIGHT_DEF);
    col = int'(col_pos);
    row = int'(row_pos);
    diff = (oldp > newp) ? int'(oldp) - int'(newp) : int'(newp) - int'(oldp);
    last_col = col >= w - 1;
    last_row = row >= h - 1;
    if (diff > int'(thr_setting)) begin
      res.display_pixel = PIX_WHITE;
      if (changed_count != COUNT_MAX) changed_count = changed_count + 1'b1;
      acc = {1'b0, sum_col} + col_pos;
      sum_col = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
      acc = {1'b0, sum_row} + row_pos;
      sum_row = acc[SUM_W] ? SUM_MAX : acc[SUM_W-1:0];
    end else if (row == h / 3 || row == (2 * h) / 3 || col == w / 3 || col == (2 * w) / 3) begin
      res.display_pixel = PIX_WHITE;
    end else begin
      res.display_pixel = newp;
    end
    if (last_col && last_row) begin
      res.frame_end = 1'b1;
      frames_closed++;
      if (changed_count > min_changed_setting) begin
        ax = 64'(sum_col) / 64'(changed_count);
        ay = 64'(sum_row) / 64'(changed_count);
        if (ax > 64'(CENT_MAX)) ax = 64'(CENT_MAX);
        if (ay > 64'(CENT_MAX)) ay = 64'(CENT_MAX);
        res.motion_found = 1'b1;
        res.centroid_x = ax[POS_W-1:0];
        res.centroid_y = ay[POS_W-1:0];
        res.region = REGION_W'(3 * grid_band(int'(ay), h) + grid_band(int'(ax), w) + 1);
        motion_frames++;
      end
      changed_count = '0;
      sum_col = '0;
      sum_row = '0;
    end
    if (last_col) begin
      col_pos = '0;
      row_pos = last_row ? '0 : row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
    return res;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] setting_of(input reg_idx_t idx);
    case (idx)
      REG_DIFF_THRESHOLD: return CFG_DATA_W'(thr_setting);
      REG_MIN_CHANGED:    return CFG_DATA_W'(min_changed_setting);
      REG_FRAME_WIDTH:    return CFG_DATA_W'(width_setting);
      default:            return CFG_DATA_W'(height_setting);
    endcase
  endfunction

  function automatic stim_row_t pixel_row(input logic [PIX_W-1:0] oldp,
                                          input logic [PIX_W-1:0] newp);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PIXEL;
    r.old_pixel = oldp;
    r.new_pixel = newp;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [PIX_W-1:0] oldp,
                                          input logic [PIX_W-1:0] newp,
                                          input logic [PIX_W-1:0] disp, input logic fe,
                                          input logic mf, input logic [REGION_W-1:0] region,
                                          input logic [POS_W-1:0] cx, input logic [POS_W-1:0] cy);
    stim_row_t r;
    r = pixel_row(oldp, newp);
    r.typed = 1'b1;
    r.want = '{disp, fe, mf, region, cx, cy};
    return r;
  endfunction

  function automatic stim_row_t write_row(input reg_idx_t idx,
                                          input logic [CFG_DATA_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  always @(negedge clk) begin : ready_pattern
    int pick;
    if (!stalls_enabled) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        stall_left <= (pick < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
      end
    end
  end

  always @(posedge clk) begin : check_overlay
    overlay_t got;
    overlay_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_display_pixel, out_frame_end, out_motion_found, out_region,
              out_centroid_x, out_centroid_y};
      if (expected_overlay_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected transfer pix=%0d end=%0b motion=%0b region=%0d cx=%0d cy=%0d",
                   $time, got.display_pixel, got.frame_end, got.motion_found, got.region,
                   got.centroid_x, got.centroid_y);
      end else begin
        want = expected_overlay_q.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display({"%0t: mismatch expected pix=%0d end=%0b motion=%0b region=%0d cx=%0d ",
                      "cy=%0d, actual pix=%0d end=%0b motion=%0b region=%0d cx=%0d cy=%0d"},
                     $time, want.display_pixel, want.frame_end, want.motion_found, want.region,
                     want.centroid_x, want.centroid_y, got.display_pixel, got.frame_end,
                     got.motion_found, got.region, got.centroid_x, got.centroid_y);
        end
      end
    end
  end

  task automatic read_reg(input reg_idx_t idx);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== setting_of(idx)) begin
      error_count++;
      if (error_count <= MAX_REPORTS)
        $display("%0t: register %s readback expected 0x%0h, actual 0x%0h", $time, idx.name(),
                 setting_of(idx), prdata);
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_DIFF_THRESHOLD: thr_setting = value[PIX_W-1:0];
      REG_MIN_CHANGED:    min_changed_setting = value[COUNT_W-1:0];
      REG_FRAME_WIDTH:    width_setting = value[SIZE_W-1:0];
      default:            height_setting = value[SIZE_W-1:0];
    endcase
    reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    read_reg(idx);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] oldp, input logic [PIX_W-1:0] newp,
                            input logic typed, input overlay_t want);
    overlay_t predicted;
    int       gap;
    int       pick;
    gap = 0;
    if (gaps_enabled) begin
      pick = $urandom_range(0, 99);
      if (pick >= 92) gap = $urandom_range(8, 25);
      else if (pick >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_old_pixel <= oldp;
    in_new_pixel <= newp;
    do @(posedge clk); while (!in_ready);
    predicted = predict_overlay(oldp, newp);
    expected_overlay_q.push_back(typed ? want : predicted);
    pixels_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_overlay_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Pick a pair near the threshold, clearly changed, or fully random.
  task automatic random_pair(output logic [PIX_W-1:0] oldp, output logic [PIX_W-1:0] newp);
    int d;
    int lo;
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: d = $urandom_range(0, int'(thr_setting));
      4, 5, 6:    d = (thr_setting == PIX_WHITE) ? 255 : $urandom_range(int'(thr_setting) + 1, 255);
      7:          d = int'(thr_setting);
      8:          d = int'(thr_setting) + 1;
      default:    d = -1;
    endcase
    if (d < 0 || d > 255) begin
      oldp = PIX_W'($urandom());
      newp = PIX_W'($urandom());
    end else begin
      lo = $urandom_range(0, 255 - d);
      if ($urandom_range(0, 1) == 1) begin
        oldp = PIX_W'(lo);
        newp = PIX_W'(lo + d);
      end else begin
        oldp = PIX_W'(lo + d);
        newp = PIX_W'(lo);
      end
    end
  endtask

  initial begin : stimulus
    reg_idx_t              r;
    stim_row_t             row;
    logic [CFG_DATA_W-1:0] thr_v;
    logic [CFG_DATA_W-1:0] min_v;
    logic [CFG_DATA_W-1:0] width_v;
    logic [CFG_DATA_W-1:0] height_v;
    logic [CFG_DATA_W-1:0] junk;
    logic [PIX_W-1:0]      oldp;
    logic [PIX_W-1:0]      newp;
    int                    n_items;

    directed_rows.push_back(typed_row(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(typed_row(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(typed_row(8'd0, 8'd255, PIX_WHITE, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(typed_row(8'd255, 8'd0, PIX_WHITE, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(typed_row(8'd30, 8'd0, 8'd0, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(typed_row(8'd0, 8'd31, PIX_WHITE, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(pixel_row(8'd170, 8'd85));
    directed_rows.push_back(pixel_row(8'd85, 8'd170));
    directed_rows.push_back(write_row(REG_DIFF_THRESHOLD, 32'hABCD_EF00));
    directed_rows.push_back(write_row(REG_MIN_CHANGED, 32'd0));
    directed_rows.push_back(write_row(REG_FRAME_WIDTH, 32'd0));
    directed_rows.push_back(write_row(REG_FRAME_HEIGHT, 32'd1));
    directed_rows.push_back(pixel_row(8'd9, 8'd9));
    directed_rows.push_back(typed_row(8'd9, 8'd9, PIX_WHITE, 1'b1, 1'b0, '0, '0, '0));
    directed_rows.push_back(typed_row(8'd0, 8'd1, PIX_WHITE, 1'b1, 1'b1, 4'd9, '0, '0));
    directed_rows.push_back(write_row(REG_DIFF_THRESHOLD, 32'hFFFF_FFFF));
    directed_rows.push_back(write_row(REG_MIN_CHANGED, 32'hFFFF_FFFF));
    directed_rows.push_back(write_row(REG_FRAME_WIDTH, 32'd3));
    directed_rows.push_back(write_row(REG_FRAME_HEIGHT, 32'd3));
    directed_rows.push_back(typed_row(8'd255, 8'd0, 8'd0, 1'b0, 1'b0, '0, '0, '0));
    directed_rows.push_back(pixel_row(8'd0, 8'd0));
    directed_rows.push_back(pixel_row(8'd1, 8'd254));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < r.num(); i++) read_reg(reg_idx_t'(i));

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        write_reg(row.idx, row.value);
      end else begin
        send_pixel(row.old_pixel, row.new_pixel, row.typed, row.want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      junk = ($urandom_range(0, 1) == 1) ? ($urandom() & 32'hFF00_0000) : '0;
      case (p)
        0: begin
          thr_v = 32'h1234_56FF;
          min_v = 32'h0040_0000;
          width_v = 32'd5;
          height_v = 32'd4;
          n_items = 25;
        end
        1: begin
          thr_v = 32'd0;
          min_v = 32'd0;
          width_v = 32'd0;
          height_v = 32'd0;
          n_items = 12;
        end
        2: begin
          thr_v = $urandom_range(0, 60);
          min_v = 32'd3;
          width_v = 32'd2048;
          height_v = 32'd1;
          n_items = 60;
        end
        3: begin
          thr_v = 32'd20;
          min_v = 32'd1;
          width_v = 32'd3;
          height_v = 32'd2;
          n_items = 12;
        end
        4: begin
          thr_v = 32'd20;
          min_v = 32'd2;
          width_v = 32'd1;
          height_v = 32'hF000_0FFF;
          n_items = 60;
        end
        5: begin
          thr_v = 32'd25;
          min_v = 32'd0;
          width_v = 32'd4;
          height_v = 32'd3;
          n_items = 20;
        end
        default: begin
          case ($urandom_range(0, 9))
            0:       thr_v = 32'd0;
            1:       thr_v = 32'd255;
            default: thr_v = $urandom_range(5, 80);
          endcase
          thr_v = thr_v | junk;
          min_v = $urandom_range(0, 12) | junk;
          width_v = $urandom_range(1, 8) | junk;
          height_v = $urandom_range(1, 6) | junk;
          n_items = $urandom_range(25, 45);
        end
      endcase
      drain_results();
      write_reg(REG_DIFF_THRESHOLD, thr_v);
      write_reg(REG_MIN_CHANGED, min_v);
      write_reg(REG_FRAME_WIDTH, width_v);
      write_reg(REG_FRAME_HEIGHT, height_v);
      gaps_enabled = $urandom_range(0, 3) != 0;
      stalls_enabled = $urandom_range(0, 3) != 0;
      repeat (n_items) begin
        random_pair(oldp, newp);
        send_pixel(oldp, newp, 1'b0, '0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d pixel transfers, %0d register writes and %0d closed frames",
             pixels_sent, reg_writes, frames_closed);
    $display("with %0d frames reporting motion; %0d mismatches seen", motion_frames, error_count);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/fdmd_pkg.sv
rtl/fdmd_cfg.sv
rtl/fdmd_front.sv
rtl/fdmd_queue.sv
rtl/fdmd_back.sv
rtl/frame_difference_motion_detector_top.sv
verif/frame_difference_motion_detector_top_tb.sv
